// ===== rtl/bba_pkg.sv =====
`default_nettype none
// Shared package of the block bitmap allocator: request and status codes,
// controller state encoding and the command/status bundles between modules.
// No dependencies.
package bba_pkg;

  // Field widths of the request, result and register interfaces.
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 13;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // Request codes.
  localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEST  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STS_RANGE = 2'd3;

  // Register select (word address bit) and reset value of the block count.
  localparam logic                REG_BLOCK_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0]  BLOCK_COUNT_RST = 13'd4096;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_RESOLVE,
    S_SCAN_FIRST,
    S_SCAN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;     // write a zero word at the pointer and advance it
    logic latch;      // capture the request and rewind the pointer
    logic look_rd;    // read the word that holds the requested block
    logic resolve;    // finish a mark, test or reserved request
    logic scan_rd;    // read the word at the pointer and advance it
    logic scan_eval;  // search the word read in the previous cycle
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // pointer is on the last map word
    logic scan_hit;   // searched word holds a free block below the limit
    logic scan_end;   // searched word is the last one below the limit
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/block_bitmap_allocator.sv =====
`default_nettype none
// Top level of the block bitmap allocator: configuration register port,
// controller and datapath. Depends on bba_pkg, bba_ctrl and bba_dpath.
//
// A request is taken when start is high and busy is low; its result appears
// on the result ports for exactly one cycle with done high, and there is no
// way to hold it off, so the receiver must capture it in that cycle. Mark,
// test and reserved requests pass through one map read and then one update
// before their result is registered. Allocate walks the map one word per
// cycle through the single read port; the number of words searched is at
// most MAX_BLOCKS / WORD_BITS, rounded up, with WORD_BITS rounded up to a
// power of two (64 with the defaults). Busy is low again in the cycle done
// is high, so the next request may be taken then. After reset the map is
// cleared one word per cycle, during which busy stays high; the block_count
// register may be written at any time the block is idle, at byte address 0.
module block_bitmap_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bba_pkg::ACTION_W-1:0]  action,
  input  wire logic [bba_pkg::INDEX_W-1:0]   block_index,
  // Result channel
  output logic                               done,
  output logic [bba_pkg::STATUS_W-1:0]       status,
  output logic                               was_used,
  output logic [bba_pkg::INDEX_W-1:0]        granted_index,
  output logic [bba_pkg::COUNT_W-1:0]        used_count,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [bba_pkg::DATA_W-1:0]    pwdata,
  output logic [bba_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  logic [bba_pkg::COUNT_W-1:0] block_count;
  logic                        reg_wr;
  bba_pkg::cmd_t               cmd;
  bba_pkg::sts_t               sts;

  // Register access completes in the access cycle with no wait states.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == bba_pkg::REG_BLOCK_COUNT);

  // Block count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= bba_pkg::BLOCK_COUNT_RST;
    end else if (reg_wr) begin
      block_count <= pwdata[bba_pkg::COUNT_W-1:0];
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    if (paddr[2] == bba_pkg::REG_BLOCK_COUNT) begin
      prdata = bba_pkg::DATA_W'(block_count);
    end
  end

  bba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  bba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (action),
    .block_index   (block_index),
    .block_count   (block_count),
    .sts           (sts),
    .done          (done),
    .status        (status),
    .was_used      (was_used),
    .granted_index (granted_index),
    .used_count    (used_count)
  );

endmodule
`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
`default_nettype none
// Controller of the block bitmap allocator: sequences the clearing pass,
// single-bit requests and the first-fit scan. Depends on bba_pkg.
module bba_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [bba_pkg::ACTION_W-1:0]  action,
  input  wire bba_pkg::sts_t                 sts,
  output bba_pkg::cmd_t                      cmd,
  output logic                               busy
);

  bba_pkg::state_t state;
  bba_pkg::state_t state_next;

  // State register; reset starts the clearing pass over the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      bba_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          if (action == bba_pkg::ACT_ALLOC) begin
            state_next = bba_pkg::S_SCAN_FIRST;
          end else begin
            state_next = bba_pkg::S_LOOKUP;
          end
        end
      end
      bba_pkg::S_LOOKUP: begin
        cmd.look_rd = 1'b1;
        state_next  = bba_pkg::S_RESOLVE;
      end
      bba_pkg::S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = bba_pkg::S_IDLE;
      end
      bba_pkg::S_SCAN_FIRST: begin
        cmd.scan_rd = 1'b1;
        state_next  = bba_pkg::S_SCAN;
      end
      bba_pkg::S_SCAN: begin
        // Read the next word while searching the one already fetched.
        cmd.scan_rd   = 1'b1;
        cmd.scan_eval = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bba_dpath.sv =====
`default_nettype none
// Datapath of the block bitmap allocator: the used-block map memory, the
// word search, the used-block counter and the result registers.
// Depends on bba_pkg; driven by bba_ctrl.
module bba_dpath #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bba_pkg::cmd_t                 cmd,
  input  wire logic [bba_pkg::ACTION_W-1:0]  action,
  input  wire logic [bba_pkg::INDEX_W-1:0]   block_index,
  input  wire logic [bba_pkg::COUNT_W-1:0]   block_count,
  output bba_pkg::sts_t                      sts,
  output logic                               done,
  output logic [bba_pkg::STATUS_W-1:0]       status,
  output logic                               was_used,
  output logic [bba_pkg::INDEX_W-1:0]        granted_index,
  output logic [bba_pkg::COUNT_W-1:0]        used_count
);

  // Map words are rounded up to a power of two so that a block index splits
  // into a word address and a bit position without division.
  localparam int WB_W      = $clog2(WORD_BITS);
  localparam int WORD_W    = 1 << WB_W;
  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int LIM_W     = (CNT_W > bba_pkg::COUNT_W) ? CNT_W : bba_pkg::COUNT_W;
  localparam int BASE_W    = ADDR_W + WB_W;
  localparam int CMP_W     = ((LIM_W > BASE_W) ? LIM_W : BASE_W) + 1;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

  logic [WORD_W-1:0]            map_mem [MAP_WORDS];
  logic [WORD_W-1:0]            rd_data;
  logic [ADDR_W-1:0]            rd_ptr;
  logic [ADDR_W-1:0]            ptr;
  logic [bba_pkg::ACTION_W-1:0] req_action;
  logic [bba_pkg::INDEX_W-1:0]  req_index;
  logic [CNT_W-1:0]             used_total;

  logic [LIM_W-1:0]  limit;
  logic [CMP_W-1:0]  lim_c;
  logic [CMP_W-1:0]  base_c;
  logic [CMP_W-1:0]  room;
  logic [BASE_W-1:0] base;
  logic [WORD_W-1:0] avail;
  logic [WB_W-1:0]   hit_pos;
  logic              scan_hit;
  logic              scan_end;
  logic [ADDR_W-1:0] look_addr;
  logic [WB_W-1:0]   bit_sel;
  logic              in_range;
  logic              cur_bit;
  logic              mark_set;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              scan_done;

  // Effective block count, limited to the size of the map.
  assign limit = (LIM_W'(block_count) > LIM_W'(MAX_BLOCKS)) ?
                 LIM_W'(MAX_BLOCKS) : LIM_W'(block_count);
  assign lim_c = CMP_W'(limit);

  // Single-block request: word address, bit position and range check.
  assign look_addr = ADDR_W'(req_index >> WB_W);
  assign bit_sel   = req_index[WB_W-1:0];
  assign in_range  = CMP_W'(req_index) < lim_c;
  assign cur_bit   = rd_data[bit_sel];
  assign mark_set  = cmd.resolve && (req_action == bba_pkg::ACT_MARK) &&
                     in_range && !cur_bit;

  // Scan: how many blocks of the fetched word lie below the limit.
  assign base   = {rd_ptr, WB_W'(0)};
  assign base_c = CMP_W'(base);
  assign room   = (lim_c > base_c) ? (lim_c - base_c) : '0;
  assign scan_end = room <= CMP_W'(WORD_W);

  // Free blocks of the fetched word that are below the limit.
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      avail[j] = !rd_data[j] && (CMP_W'(j) < room);
    end
  end

  // Lowest free position in the fetched word.
  always_comb begin
    hit_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (avail[j]) begin
        hit_pos = WB_W'(j);
      end
    end
  end

  assign scan_hit  = |avail;
  assign scan_done = cmd.scan_eval && (scan_hit || scan_end);

  assign sts.clr_last = (ptr == LAST_WORD);
  assign sts.scan_hit = scan_hit;
  assign sts.scan_end = scan_end;

  // Map write port: clearing pass, marked block or granted block.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = '0;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (mark_set) begin
      wr_en   = 1'b1;
      wr_addr = look_addr;
      wr_data = rd_data | (WORD_W'(1) << bit_sel);
    end else if (cmd.scan_eval && scan_hit) begin
      wr_en   = 1'b1;
      wr_addr = rd_ptr;
      wr_data = rd_data | (WORD_W'(1) << hit_pos);
    end
  end

  // Map read port: scan pointer or the requested block's word.
  assign rd_en   = cmd.look_rd || cmd.scan_rd;
  assign rd_addr = cmd.scan_rd ? ptr : look_addr;

  // Map memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
      rd_ptr  <= rd_addr;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_action <= action;
      req_index  <= block_index;
    end
  end

  // Word pointer, used-block counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      used_total <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.resolve || scan_done;
      if (cmd.latch) begin
        ptr <= '0;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
        ptr <= (ptr == LAST_WORD) ? ptr : ptr + ADDR_W'(1);
      end
      if (mark_set || (cmd.scan_eval && scan_hit)) begin
        used_total <= used_total + CNT_W'(1);
      end
    end
  end

  // Result fields of the finished transaction.
  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      granted_index <= '0;
      case (req_action)
        bba_pkg::ACT_MARK: begin
          if (!in_range) begin
            status   <= bba_pkg::STS_RANGE;
            was_used <= 1'b0;
          end else if (cur_bit) begin
            status   <= bba_pkg::STS_DUP;
            was_used <= 1'b1;
          end else begin
            status   <= bba_pkg::STS_OK;
            was_used <= 1'b0;
          end
        end
        bba_pkg::ACT_TEST: begin
          if (!in_range) begin
            status   <= bba_pkg::STS_RANGE;
            was_used <= 1'b0;
          end else begin
            status   <= bba_pkg::STS_OK;
            was_used <= cur_bit;
          end
        end
        default: begin
          status   <= bba_pkg::STS_RANGE;
          was_used <= 1'b0;
        end
      endcase
    end else if (scan_done) begin
      was_used <= 1'b0;
      if (scan_hit) begin
        status        <= bba_pkg::STS_OK;
        granted_index <= bba_pkg::INDEX_W'({rd_ptr, hit_pos});
      end else begin
        status        <= bba_pkg::STS_FULL;
        granted_index <= '0;
      end
    end
  end

  // The counter only changes while a transaction is in progress, so it is
  // settled whenever the result strobe is high.
  assign used_count = bba_pkg::COUNT_W'(used_total);

endmodule
`default_nettype wire

// ===== test/block_bitmap_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of block_bitmap_allocator: directed and random mark, allocate,
// test and reserved requests against a first-fit predictor, under several block counts.
// Depends on bba_pkg and the block_bitmap_allocator RTL.
module block_bitmap_allocator_tb;

  localparam int MAP_BLOCKS = 4096;
  localparam int MAP_WORD_BITS = 64;
  localparam int CLK_HALF = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;

  // The reserved request code, which the package leaves unnamed.
  localparam logic [bba_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;
  // Byte address of the block count register.
  localparam logic [bba_pkg::PADDR_W-1:0] ADDR_BLOCK_COUNT =
    {bba_pkg::REG_BLOCK_COUNT, 2'b00};

  typedef struct packed {
    logic [bba_pkg::STATUS_W-1:0] status;
    logic                         was_used;
    logic [bba_pkg::INDEX_W-1:0]  granted;
    logic [bba_pkg::COUNT_W-1:0]  count;
  } alloc_result_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [bba_pkg::ACTION_W-1:0] action;
  logic [bba_pkg::INDEX_W-1:0]  block_index;
  logic                         done;
  logic [bba_pkg::STATUS_W-1:0] status;
  logic                         was_used;
  logic [bba_pkg::INDEX_W-1:0]  granted_index;
  logic [bba_pkg::COUNT_W-1:0]  used_count;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bba_pkg::PADDR_W-1:0]  paddr;
  logic [bba_pkg::DATA_W-1:0]   pwdata;
  logic [bba_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Shadow of the block state and its register.
  bit [MAP_BLOCKS-1:0]          block_used;
  int unsigned                  used_blocks;
  logic [bba_pkg::COUNT_W-1:0]  cfg_count;

  alloc_result_t pending_results[$];
  int            mismatches;
  int            requests_sent;
  int            status_seen[4];
  int            cycle_count;

  block_bitmap_allocator #(
    .MAX_BLOCKS(MAP_BLOCKS),
    .WORD_BITS (MAP_WORD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .block_index  (block_index),
    .done         (done),
    .status       (status),
    .was_used     (was_used),
    .granted_index(granted_index),
    .used_count   (used_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("block_bitmap_allocator_tb: FAIL");
      $finish;
    end
  end

  // Number of blocks actually in play: the register, limited to the map size.
  function automatic int unsigned effective_limit();
    return (cfg_count > MAP_BLOCKS) ? MAP_BLOCKS : int'(cfg_count);
  endfunction

  // First-fit allocator prediction; updates the shadow map and count.
  function automatic alloc_result_t predict_request(
    logic [bba_pkg::ACTION_W-1:0] act,
    logic [bba_pkg::INDEX_W-1:0]  idx
  );
    alloc_result_t res;
    int unsigned   lim;
    lim = effective_limit();
    res.status = bba_pkg::STS_OK;
    res.was_used = 1'b0;
    res.granted = '0;
    case (act)
      bba_pkg::ACT_MARK: begin
        if (idx >= lim) begin
          res.status = bba_pkg::STS_RANGE;
        end else if (block_used[idx]) begin
          res.was_used = 1'b1;
          res.status = bba_pkg::STS_DUP;
        end else begin
          block_used[idx] = 1'b1;
          used_blocks++;
        end
      end
      bba_pkg::ACT_ALLOC: begin
        res.status = bba_pkg::STS_FULL;
        for (int unsigned k = 0; k < lim; k++) begin
          if (!block_used[k]) begin
            block_used[k] = 1'b1;
            used_blocks++;
            res.granted = k[bba_pkg::INDEX_W-1:0];
            res.status = bba_pkg::STS_OK;
            break;
          end
        end
      end
      bba_pkg::ACT_TEST: begin
        if (idx >= lim) res.status = bba_pkg::STS_RANGE;
        else res.was_used = block_used[idx];
      end
      default: begin
        res.status = bba_pkg::STS_RANGE;
      end
    endcase
    res.count = used_blocks[bba_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // Result checker: every strobe is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && done) begin
      got.status = status;
      got.was_used = was_used;
      got.granted = granted_index;
      got.count = used_count;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("Unexpected result at cycle %0d: status %0d was_used %0d",
                   cycle_count, got.status, got.was_used);
          $display("  granted %0d count %0d", got.granted, got.count);
        end
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.was_used !== want.was_used ||
            got.granted !== want.granted || got.count !== want.count) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("Mismatch at cycle %0d: expected status %0d was_used %0d granted %0d",
                     cycle_count, want.status, want.was_used, want.granted);
            $display("  count %0d, got status %0d was_used %0d granted %0d count %0d",
                     want.count, got.status, got.was_used, got.granted, got.count);
          end
          mismatches++;
        end
      end
    end
  end

  // Sends one request and records its predicted result once it is taken.
  task automatic send_request(input logic [bba_pkg::ACTION_W-1:0] act,
                              input logic [bba_pkg::INDEX_W-1:0]  idx);
    start <= 1'b1;
    action <= act;
    block_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_request(act, idx));
    requests_sent++;
  endtask

  // Randomly holds start low for a while; long gaps land anywhere in a scan.
  task automatic pace_sender(input int idle_pct);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One APB transaction: setup cycle, then access until pready.
  task automatic apb_transfer(input  logic                        wr,
                              input  logic [bba_pkg::PADDR_W-1:0] addr,
                              input  logic [bba_pkg::DATA_W-1:0]  wdata,
                              output logic [bba_pkg::DATA_W-1:0]  rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until the block is idle, then writes and reads back the block count.
  task automatic set_block_count(input logic [bba_pkg::COUNT_W-1:0] value);
    logic [bba_pkg::DATA_W-1:0] readback;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    apb_transfer(1'b1, ADDR_BLOCK_COUNT, bba_pkg::DATA_W'(value), readback);
    cfg_count = value;
    apb_transfer(1'b0, ADDR_BLOCK_COUNT, '0, readback);
    if (readback !== bba_pkg::DATA_W'(value)) begin
      if (mismatches < REPORT_LIMIT)
        $display("Block count read back as %0d, expected %0d", readback, value);
      mismatches++;
    end
  endtask

  // Picks an index: anywhere, below the limit, or around the limit.
  function automatic logic [bba_pkg::INDEX_W-1:0] pick_index(input int unsigned lim);
    int unsigned sel;
    int          near;
    sel = $urandom_range(99);
    if (sel < 40 || lim == 0) begin
      return bba_pkg::INDEX_W'($urandom_range(0, MAP_BLOCKS - 1));
    end
    if (sel < 75) begin
      return bba_pkg::INDEX_W'($urandom_range(0, lim - 1));
    end
    near = int'(lim) + int'($urandom_range(0, 3)) - 2;
    if (near < 0) near = 0;
    if (near > MAP_BLOCKS - 1) near = MAP_BLOCKS - 1;
    return near[bba_pkg::INDEX_W-1:0];
  endfunction

  // Edge cases: duplicates, extreme indices, reserved code, counts of 0, 1 and above the map.
  task automatic test_directed();
    send_request(bba_pkg::ACT_TEST, 12'd0);
    send_request(bba_pkg::ACT_MARK, 12'd0);
    send_request(bba_pkg::ACT_MARK, 12'd0);
    send_request(bba_pkg::ACT_TEST, 12'd0);
    send_request(bba_pkg::ACT_ALLOC, 12'd4095);
    send_request(bba_pkg::ACT_MARK, 12'd4095);
    send_request(bba_pkg::ACT_TEST, 12'd4095);
    send_request(bba_pkg::ACT_MARK, 12'd4095);
    send_request(ACT_RESERVED, 12'd4095);
    send_request(bba_pkg::ACT_TEST, 12'hAAA);
    send_request(bba_pkg::ACT_MARK, 12'h555);
    send_request(bba_pkg::ACT_TEST, 12'h555);
    send_request(bba_pkg::ACT_ALLOC, 12'h555);
    // A single block, already taken: nothing to grant, the rest out of range.
    set_block_count(13'd1);
    send_request(bba_pkg::ACT_ALLOC, 12'd0);
    send_request(bba_pkg::ACT_MARK, 12'd1);
    send_request(bba_pkg::ACT_TEST, 12'd4095);
    send_request(bba_pkg::ACT_TEST, 12'd0);
    // No blocks at all.
    set_block_count(13'd0);
    send_request(bba_pkg::ACT_ALLOC, 12'd0);
    send_request(bba_pkg::ACT_MARK, 12'd0);
    send_request(bba_pkg::ACT_TEST, 12'd0);
    send_request(ACT_RESERVED, 12'd0);
    // A count beyond the map is limited to the map size.
    set_block_count(13'h1FFF);
    send_request(bba_pkg::ACT_TEST, 12'd4095);
    send_request(bba_pkg::ACT_ALLOC, 12'd0);
  endtask

  // Allocates, with a test mixed in about one time in five, count + 4 requests in all.
  task automatic test_fill_to_full(input logic [bba_pkg::COUNT_W-1:0] count,
                                   input int idle_pct);
    set_block_count(count);
    repeat (int'(count) + 4) begin
      pace_sender(idle_pct);
      if ($urandom_range(4) == 0) begin
        send_request(bba_pkg::ACT_TEST, pick_index(effective_limit()));
      end else begin
        send_request(bba_pkg::ACT_ALLOC,
                     bba_pkg::INDEX_W'($urandom_range(0, MAP_BLOCKS - 1)));
      end
    end
  endtask

  // Random mix of all request codes under one block count.
  task automatic test_random_mix(input logic [bba_pkg::COUNT_W-1:0] count, input int items,
                                 input int idle_pct);
    int unsigned                  pick;
    logic [bba_pkg::ACTION_W-1:0] act;
    set_block_count(count);
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 35) act = bba_pkg::ACT_ALLOC;
      else if (pick < 65) act = bba_pkg::ACT_MARK;
      else if (pick < 95) act = bba_pkg::ACT_TEST;
      else act = ACT_RESERVED;
      pace_sender(idle_pct);
      send_request(act, pick_index(effective_limit()));
    end
  endtask

  // Test sequence.
  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    action <= bba_pkg::ACT_MARK;
    block_index <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    block_used = '0;
    used_blocks = 0;
    cfg_count = bba_pkg::BLOCK_COUNT_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_to_full(13'd130, 46);
    test_random_mix(13'd4096, 110, 0);
    test_random_mix(13'd200, 110, 46);
    test_random_mix(13'h1FFF, 100, 25);
    test_random_mix(13'd65, 60, 46);
    test_random_mix(bba_pkg::COUNT_W'($urandom_range(1, 4096)), 100, 25);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests, block counts 0, 1, 65, 130, 200, 4096, 8191 and a random one.",
             requests_sent);
    $display("%0d ok, %0d already used, %0d full, %0d out of range; %0d mismatches.",
             status_seen[bba_pkg::STS_OK], status_seen[bba_pkg::STS_DUP],
             status_seen[bba_pkg::STS_FULL], status_seen[bba_pkg::STS_RANGE], mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("block_bitmap_allocator_tb: PASS");
    end else begin
      $display("block_bitmap_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_dpath.sv
rtl/block_bitmap_allocator.sv
test/block_bitmap_allocator_tb.sv
